### rtl/pjpq_pkg.sv
package pjpq_pkg;

	localparam int unsigned CAPACITY_DEF = 16;

	localparam int unsigned POS_W = 5;
	localparam int unsigned IDX_W = 4;
	localparam int unsigned CNT_W = 5;
	localparam int unsigned TAG_W = 16;
	localparam int unsigned PRI_W = 4;

	localparam logic [2:0] OP_INSERT  = 3'd0;
	localparam logic [2:0] OP_DELETE  = 3'd1;
	localparam logic [2:0] OP_DEQUEUE = 3'd2;
	localparam logic [2:0] OP_PEEK    = 3'd3;
	localparam logic [2:0] OP_SEARCH  = 3'd4;
	localparam logic [2:0] OP_READ    = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_RANGE    = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [POS_W-1:0] position;
		logic [TAG_W-1:0] doc_tag;
		logic [TAG_W-1:0] user_tag;
		logic [TAG_W-1:0] page_total;
		logic [TAG_W-1:0] doc_bytes;
		logic [PRI_W-1:0] priority_req;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [IDX_W-1:0] found_index;
		logic [TAG_W-1:0] out_doc_tag;
		logic [TAG_W-1:0] out_user_tag;
		logic [TAG_W-1:0] out_pages;
		logic [TAG_W-1:0] out_bytes;
		logic [PRI_W-1:0] out_priority;
		logic [CNT_W-1:0] entry_count;
	} rsp_t;

	// one table entry as stored in memory
	typedef struct packed {
		logic [PRI_W-1:0] pri;
		logic [TAG_W-1:0] doc;
		logic [TAG_W-1:0] user;
		logic [TAG_W-1:0] pages;
		logic [TAG_W-1:0] bytes;
	} entry_t;

endpackage

### rtl/print_job_priority_queue_unit.sv
// Rejected commands answer in the cycle after accept; read, peek and search walk the table
// through one memory read port. Insert appends directly, else first shifts entries up one slot.
// Delete/dequeue add a shift-down pass after the scan unless the last entry goes.
// One command at a time: start is taken only while busy is low.
// Reset clears count and control state but not the table; no entry is read before written.
// The done strobe lasts one cycle and cannot be stalled by the receiver.
module print_job_priority_queue_unit #(
	parameter int unsigned CAPACITY = pjpq_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  pjpq_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done,
	output pjpq_pkg::rsp_t result
);
	import pjpq_pkg::*;

	localparam int unsigned AW   = $clog2(CAPACITY);
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHDN,
		S_SHUP,
		S_WNEW
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [2:0]      op_q;
	logic [AW-1:0]   pos_q;
	entry_t          new_q;
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   end_q;
	logic            iss_q;
	logic            rv_s1;
	logic            rlast_s1;
	logic [AW-1:0]   ridx_s1;
	entry_t          rdata_s1;
	entry_t          best_q;
	logic [AW-1:0]   sel_q;
	logic            hit_q;
	logic            done_q;
	rsp_t            result_q;

	entry_t          table_q [CAPACITY];

	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	entry_t          mem_wdata;

	logic            accept;
	logic            issue_last;
	logic            scan_take;
	logic [AW-1:0]   sel_nx;
	entry_t          best_nx;
	logic            hit_nx;
	logic [AW-1:0]   cnt_m1;
	logic [CMPW-1:0] pos_ext;
	logic [CMPW-1:0] cnt_ext;
	entry_t          cmd_entry;

	function automatic rsp_t pack_rsp(input logic [2:0] st, input logic [AW-1:0] idx,
			input entry_t e, input logic [CW-1:0] cnt);
		rsp_t r;
		r.status       = st;
		r.found_index  = IDX_W'(idx);
		r.out_doc_tag  = e.doc;
		r.out_user_tag = e.user;
		r.out_pages    = e.pages;
		r.out_bytes    = e.bytes;
		r.out_priority = e.pri;
		r.entry_count  = CNT_W'(cnt);
		return r;
	endfunction

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;
	assign accept = start && !busy;

	assign pos_ext = CMPW'(cmd.position);
	assign cnt_ext = CMPW'(count_q);
	assign cnt_m1  = AW'(count_q - 1'b1);

	assign cmd_entry.pri   = cmd.priority_req;
	assign cmd_entry.doc   = cmd.doc_tag;
	assign cmd_entry.user  = cmd.user_tag;
	assign cmd_entry.pages = cmd.page_total;
	assign cmd_entry.bytes = cmd.doc_bytes;

	assign mem_re     = iss_q;
	assign mem_raddr  = ptr_q;
	assign issue_last = iss_q && (ptr_q == end_q);

	// scan beat evaluation: max keeps first strictly greater, search keeps first match
	always_comb begin
		scan_take = 1'b0;
		if (rv_s1) begin
			case (op_q) inside
				OP_DEQUEUE, OP_PEEK: scan_take = (ridx_s1 == '0) || (rdata_s1.pri > best_q.pri);
				OP_SEARCH:           scan_take = !hit_q && (rdata_s1.doc == new_q.doc);
				default:             scan_take = 1'b1;
			endcase
		end
		sel_nx  = scan_take ? ridx_s1 : sel_q;
		best_nx = scan_take ? rdata_s1 : best_q;
		hit_nx  = hit_q || scan_take;
	end

	// write port: shift beats write the entry read in the previous cycle to its neighbor
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ridx_s1;
		mem_wdata = rdata_s1;
		unique case (state_q)
			S_SHDN: begin
				mem_we    = rv_s1;
				mem_waddr = ridx_s1 - 1'b1;
			end
			S_SHUP: begin
				mem_we    = rv_s1;
				mem_waddr = ridx_s1 + 1'b1;
			end
			S_WNEW: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = new_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			table_q[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (mem_re)
			rdata_s1 <= table_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			op_q     <= OP_INSERT;
			pos_q    <= '0;
			new_q    <= '0;
			ptr_q    <= '0;
			end_q    <= '0;
			iss_q    <= 1'b0;
			rv_s1    <= 1'b0;
			rlast_s1 <= 1'b0;
			ridx_s1  <= '0;
			best_q   <= '0;
			sel_q    <= '0;
			hit_q    <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q   <= 1'b0;
			rv_s1    <= mem_re;
			rlast_s1 <= issue_last;
			ridx_s1  <= ptr_q;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= cmd.opcode;
						pos_q <= AW'(cmd.position);
						new_q <= cmd_entry;
						hit_q <= 1'b0;
						unique case (cmd.opcode) inside
							OP_INSERT: begin
								if (pos_ext > cnt_ext) begin
									done_q   <= 1'b1;
									result_q <= pack_rsp(ST_RANGE, '0, '0, count_q);
								end else if (count_q == CW'(CAPACITY)) begin
									done_q   <= 1'b1;
									result_q <= pack_rsp(ST_FULL, '0, '0, count_q);
								end else if (pos_ext == cnt_ext) begin
									state_q <= S_WNEW;
								end else begin
									state_q <= S_SHUP;
									ptr_q   <= cnt_m1;
									end_q   <= AW'(cmd.position);
									iss_q   <= 1'b1;
								end
							end
							OP_DELETE, OP_READ: begin
								if (pos_ext >= cnt_ext) begin
									done_q   <= 1'b1;
									result_q <= pack_rsp(ST_RANGE, '0, '0, count_q);
								end else begin
									state_q <= S_SCAN;
									ptr_q   <= AW'(cmd.position);
									end_q   <= AW'(cmd.position);
									iss_q   <= 1'b1;
								end
							end
							OP_DEQUEUE, OP_PEEK, OP_SEARCH: begin
								if (count_q == '0) begin
									done_q   <= 1'b1;
									result_q <= pack_rsp((cmd.opcode == OP_SEARCH) ?
										ST_NOTFOUND : ST_EMPTY, '0, '0, count_q);
								end else begin
									state_q <= S_SCAN;
									ptr_q   <= '0;
									end_q   <= cnt_m1;
									iss_q   <= 1'b1;
								end
							end
							default: begin
								done_q   <= 1'b1;
								result_q <= pack_rsp(ST_RANGE, '0, '0, count_q);
							end
						endcase
					end
				end

				S_SCAN: begin
					if (iss_q) begin
						ptr_q <= ptr_q + 1'b1;
						if (issue_last)
							iss_q <= 1'b0;
					end
					best_q <= best_nx;
					sel_q  <= sel_nx;
					hit_q  <= hit_nx;
					if (rv_s1 && rlast_s1) begin
						if (op_q == OP_DEQUEUE || op_q == OP_DELETE) begin
							if (sel_nx == cnt_m1) begin
								state_q  <= S_IDLE;
								count_q  <= count_q - 1'b1;
								done_q   <= 1'b1;
								result_q <= pack_rsp(ST_OK, sel_nx, best_nx,
									CW'(count_q - 1'b1));
							end else begin
								state_q <= S_SHDN;
								ptr_q   <= sel_nx + 1'b1;
								end_q   <= cnt_m1;
								iss_q   <= 1'b1;
							end
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
							if (hit_nx)
								result_q <= pack_rsp(ST_OK, sel_nx, best_nx, count_q);
							else
								result_q <= pack_rsp(ST_NOTFOUND, '0, '0, count_q);
						end
					end
				end

				S_SHDN: begin
					if (iss_q) begin
						ptr_q <= ptr_q + 1'b1;
						if (issue_last)
							iss_q <= 1'b0;
					end
					if (rv_s1 && rlast_s1) begin
						state_q  <= S_IDLE;
						count_q  <= count_q - 1'b1;
						done_q   <= 1'b1;
						result_q <= pack_rsp(ST_OK, sel_q, best_q, CW'(count_q - 1'b1));
					end
				end

				S_SHUP: begin
					if (iss_q) begin
						ptr_q <= ptr_q - 1'b1;
						if (issue_last)
							iss_q <= 1'b0;
					end
					if (rv_s1 && rlast_s1)
						state_q <= S_WNEW;
				end

				S_WNEW: begin
					state_q  <= S_IDLE;
					count_q  <= count_q + 1'b1;
					done_q   <= 1'b1;
					result_q <= pack_rsp(ST_OK, pos_q, new_q, CW'(count_q + 1'b1));
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_count_moves_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (done_q && result_q.status == ST_OK))
		else $error("entry count changed without an ok result");

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("read and write hit the same entry in one cycle");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("table written while idle");

endmodule

### tb/sv/pjpq_tb_pkg.sv
package pjpq_tb_pkg;

	import pjpq_pkg::*;

	localparam int unsigned DEPTH = CAPACITY_DEF;

	// Shadow of the job table: predicts one answer per accepted command beat
	class job_queue_scoreboard;
		entry_t      jobs [DEPTH];
		int unsigned fill;
		rsp_t        answers [$];
		int unsigned failures;

		function new();
			fill = 0;
			failures = 0;
		endfunction

		function rsp_t ok_answer(int unsigned idx, entry_t e);
			rsp_t r;
			r = '0;
			r.status       = ST_OK;
			r.found_index  = IDX_W'(idx);
			r.out_doc_tag  = e.doc;
			r.out_user_tag = e.user;
			r.out_pages    = e.pages;
			r.out_bytes    = e.bytes;
			r.out_priority = e.pri;
			return r;
		endfunction

		function void drop_job(int unsigned idx);
			int unsigned i;
			for (i = idx; i + 1 < fill; i++)
				jobs[i] = jobs[i + 1];
			fill--;
		endfunction

		function void note_command(cmd_t c);
			rsp_t             r;
			entry_t           e;
			int unsigned      pos, sel, i;
			logic [PRI_W-1:0] best;
			bit               hit;
			r = '0;
			pos = c.position;
			case (c.opcode)
				OP_INSERT: begin
					// range check wins over the full check
					if (pos > fill) begin
						r.status = ST_RANGE;
					end else if (fill >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						e.pri   = c.priority_req;
						e.doc   = c.doc_tag;
						e.user  = c.user_tag;
						e.pages = c.page_total;
						e.bytes = c.doc_bytes;
						for (i = fill; i > pos; i--)
							jobs[i] = jobs[i - 1];
						jobs[pos] = e;
						fill++;
						r = ok_answer(pos, e);
					end
				end
				OP_DELETE, OP_READ: begin
					if (pos >= fill) begin
						r.status = ST_RANGE;
					end else begin
						r = ok_answer(pos, jobs[pos]);
						if (c.opcode == OP_DELETE)
							drop_job(pos);
					end
				end
				OP_DEQUEUE, OP_PEEK: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else begin
						// strictly greater from zero: ties keep the lowest slot
						best = '0;
						sel = 0;
						for (i = 0; i < fill; i++) begin
							if (jobs[i].pri > best) begin
								best = jobs[i].pri;
								sel = i;
							end
						end
						r = ok_answer(sel, jobs[sel]);
						if (c.opcode == OP_DEQUEUE)
							drop_job(sel);
					end
				end
				OP_SEARCH: begin
					hit = 1'b0;
					sel = 0;
					for (i = 0; i < fill; i++) begin
						if (!hit && jobs[i].doc == c.doc_tag) begin
							hit = 1'b1;
							sel = i;
						end
					end
					if (hit)
						r = ok_answer(sel, jobs[sel]);
					else
						r.status = ST_NOTFOUND;
				end
				default: begin
					r.status = ST_RANGE;
				end
			endcase
			r.entry_count = CNT_W'(fill);
			answers = {answers, r};
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
			if (want !== seen) begin
				$error("%s: expected %0d, got %0d", name, want, seen);
				failures++;
			end
		endfunction

		function void check_answer(rsp_t got);
			rsp_t want;
			if (answers.size() == 0) begin
				$error("answer beat with no command waiting");
				failures++;
				return;
			end
			want = answers.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("found_index", 32'(want.found_index), 32'(got.found_index));
			compare_field("out_doc_tag", 32'(want.out_doc_tag), 32'(got.out_doc_tag));
			compare_field("out_user_tag", 32'(want.out_user_tag), 32'(got.out_user_tag));
			compare_field("out_pages", 32'(want.out_pages), 32'(got.out_pages));
			compare_field("out_bytes", 32'(want.out_bytes), 32'(got.out_bytes));
			compare_field("out_priority", 32'(want.out_priority), 32'(got.out_priority));
			compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
		endfunction

		function void check_drained();
			if (answers.size() != 0) begin
				$error("%0d answers never arrived", answers.size());
				failures++;
			end
		endfunction
	endclass

endpackage

### tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pjpq_pkg::*;
	import pjpq_tb_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1800;
	localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY_DEF + 8;
	localparam int unsigned CMD_W = $bits(cmd_t);

	// opcodes the block leaves unused
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	rsp_t result;

	job_queue_scoreboard sb = new();
	int unsigned burst_left = 0;
	bit start_dropped = 1'b0;

	always begin
		#6;
		clk = 1'b1;
		#6;
		clk = 1'b0;
	end

	print_job_priority_queue_unit #(
		.CAPACITY(CAPACITY_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_answer(result);
	end

	initial begin
		#10ms;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3, 4: return 16'($urandom_range(0, 7));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cmd_t make_cmd(logic [2:0] op, int unsigned pos, logic [15:0] doc,
			logic [15:0] user, logic [15:0] pages, logic [15:0] bytes, logic [3:0] pri);
		cmd_t c;
		c.opcode       = op;
		c.position     = POS_W'(pos);
		c.doc_tag      = doc;
		c.user_tag     = user;
		c.page_total   = pages;
		c.doc_bytes    = bytes;
		c.priority_req = pri;
		return c;
	endfunction

	// steer the table size toward a target so both empty and full get hit often
	function automatic cmd_t random_cmd(int unsigned target);
		cmd_t        c;
		int unsigned n, roll, ins, rem;
		bit          grow, shrink;
		n = sb.fill;
		grow = n < target;
		shrink = n > target;
		ins = grow ? 45 : (shrink ? 8 : 22);
		rem = shrink ? 24 : 12;
		c = make_cmd(OP_INSERT, $urandom_range(0, 31), pick_word(), pick_word(), pick_word(),
			pick_word(), ($urandom_range(0, 4) == 0) ? 4'h0 : 4'($urandom));
		roll = $urandom_range(0, 99);
		if (roll < 3)
			c.opcode = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
		else if (roll < 3 + ins)
			c.opcode = OP_INSERT;
		else if (roll < 3 + ins + rem)
			c.opcode = OP_DELETE;
		else if (roll < 3 + ins + 2 * rem)
			c.opcode = OP_DEQUEUE;
		else
			case ($urandom_range(0, 2))
				0: c.opcode = OP_PEEK;
				1: c.opcode = OP_SEARCH;
				default: c.opcode = OP_READ;
			endcase
		if ($urandom_range(0, 99) < 85) begin
			if (c.opcode == OP_INSERT)
				c.position = POS_W'($urandom_range(0, n));
			else if (n > 0)
				c.position = POS_W'($urandom_range(0, n - 1));
		end
		if (c.opcode == OP_SEARCH && n > 0 && $urandom_range(0, 99) < 65)
			c.doc_tag = sb.jobs[$urandom_range(0, n - 1)].doc;
		return c;
	endfunction

	task automatic issue(cmd_t c);
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(c);
	endtask

	task automatic pause(int unsigned n);
		if (n == 0)
			return;
		start <= 1'b0;
		cmd <= cmd_t'(CMD_W'({$urandom, $urandom, $urandom}));
		repeat (n) @(posedge clk);
	endtask

	// bursts of back-to-back beats, then a gap; long gaps now and then
	task automatic beat(cmd_t c);
		int unsigned gap;
		issue(c);
		if (burst_left > 0) begin
			burst_left--;
			start_dropped = 1'b0;
			return;
		end
		burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 11);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		else
			gap = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 5);
		start_dropped = (gap > 0);
		pause(gap);
	endtask

	initial begin : stimulus
		int unsigned target, phase_left, k;
		target = 0;
		phase_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		beat(make_cmd(OP_PEEK, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_DEQUEUE, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_SEARCH, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_READ, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_DELETE, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_INSERT, 1, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 4'h5));
		beat(make_cmd(OP_SPARE_LO, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_SPARE_HI, 31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF));
		// all-zero priorities: scan picks slot 0
		beat(make_cmd(OP_INSERT, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_INSERT, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'h0));
		beat(make_cmd(OP_PEEK, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		// tie at the top priority, duplicate tags
		beat(make_cmd(OP_INSERT, 0, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003, 4'hF));
		beat(make_cmd(OP_INSERT, 3, 16'h0000, 16'hA5A5, 16'h5A5A, 16'h1234, 4'hF));
		beat(make_cmd(OP_SEARCH, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_SEARCH, 0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_SEARCH, 0, 16'h7777, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_READ, 31, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_DELETE, 4, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_INSERT, 5, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_PEEK, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_DEQUEUE, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_READ, 2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_DELETE, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		// fill up, then hit full and out of range past the end
		while (sb.fill < DEPTH)
			beat(make_cmd(OP_INSERT, $urandom_range(0, sb.fill), pick_word(), pick_word(),
				pick_word(), pick_word(), 4'($urandom)));
		beat(make_cmd(OP_INSERT, 16, 16'h0F0F, 16'hF0F0, 16'h0F0F, 16'hF0F0, 4'hA));
		beat(make_cmd(OP_INSERT, 0, 16'h0F0F, 16'hF0F0, 16'h0F0F, 16'hF0F0, 4'hA));
		beat(make_cmd(OP_INSERT, 17, 16'h0F0F, 16'hF0F0, 16'h0F0F, 16'hF0F0, 4'hA));
		beat(make_cmd(OP_READ, 15, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));
		beat(make_cmd(OP_DEQUEUE, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0));

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 5))
					0: target = 0;
					1: target = DEPTH;
					default: target = $urandom_range(0, DEPTH);
				endcase
				phase_left = $urandom_range(30, 60);
			end
			phase_left--;
			beat(random_cmd(target));
		end

		if (!start_dropped)
			start <= 1'b0;
		while (sb.answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.check_drained();
		if (sb.failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
